@@ src/rad_pkg.sv @@
// Shared types, register numbers and helpers for the x86 register access decoder.
package rad_pkg;

  localparam int unsigned IN_DATA_W  = 64;
  localparam int unsigned IN_USER_W  = 5;
  localparam int unsigned OUT_DATA_W = 16;

  // General register numbers
  localparam logic [2:0] REG_EAX = 3'd0;
  localparam logic [2:0] REG_ECX = 3'd1;
  localparam logic [2:0] REG_EDX = 3'd2;
  localparam logic [2:0] REG_EBX = 3'd3;
  localparam logic [2:0] REG_ESP = 3'd4;
  localparam logic [2:0] REG_EBP = 3'd5;
  localparam logic [2:0] REG_ESI = 3'd6;
  localparam logic [2:0] REG_EDI = 3'd7;

  localparam logic [1:0] MOD_NO_DISP = 2'd0;
  localparam logic [1:0] MOD_REG     = 2'd3;

  typedef struct packed {
    logic [31:0] immediate;
    logic [7:0]  sib_byte;
    logic [7:0]  modrm_byte;
    logic [7:0]  second_opcode;
    logic [7:0]  primary_opcode;
  } instr_data_t;

  typedef struct packed {
    logic prefix_f3;
    logic prefix_f2;
    logic call_flag;
    logic modrm_present;
    logic two_byte_form;
  } instr_flags_t;

  typedef struct packed {
    logic [7:0] writes_mask;
    logic [7:0] reads_mask;
  } access_t;

  function automatic logic [7:0] reg_bit(input logic [2:0] idx);
    reg_bit = 8'b1 << idx;
  endfunction

endpackage

@@ src/x86_register_access_decoder_top.sv @@
// Top level: input register, opcode decode and result register for register access masks.
//
//   channel | dir | tdata (low bit up)                                  | tuser (low bit up)
//   s_*     | in  | primary_opcode, second_opcode, modrm_byte, sib_byte, | two_byte_form,
//           |     | immediate                                           | modrm_present,
//           |     |                                                     | call_flag,
//           |     |                                                     | prefix_f2, prefix_f3
//   m_*     | out | reads_mask, writes_mask                             | -
//
// Two register stages: a request is captured in the input register, decoded by one
// flat table, and lands in the result register.
// One request per cycle is sustained whenever m_tready stays high.
// A stall on m_tready holds the result register, then the input register; s_tready
// drops only when both are full.
// rst clears both valid flags; payload registers are not reset.
module x86_register_access_decoder_top (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  // primary_opcode[7:0], second_opcode[15:8], modrm_byte[23:16], sib_byte[31:24],
  // immediate[63:32]
  input  logic [rad_pkg::IN_DATA_W-1:0]        s_tdata,
  // two_byte_form[0], modrm_present[1], call_flag[2], prefix_f2[3], prefix_f3[4]
  input  logic [rad_pkg::IN_USER_W-1:0]        s_tuser,
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  // reads_mask[7:0], writes_mask[15:8]
  output logic [rad_pkg::OUT_DATA_W-1:0]       m_tdata
);
  import rad_pkg::*;

  logic         in_valid;
  instr_data_t  in_data;
  instr_flags_t in_flags;
  logic         out_valid;
  access_t      out_access;
  access_t      dec_access;
  logic         out_load;
  logic         in_load;

  assign out_load = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || out_load;
  assign in_load  = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_load) begin
      in_data  <= instr_data_t'(s_tdata);
      in_flags <= instr_flags_t'(s_tuser);
    end
  end

  rad_decode u_decode (
    .data   (in_data),
    .flags  (in_flags),
    .access (dec_access)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || m_tready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_access <= dec_access;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = out_access;

endmodule

@@ src/rad_decode.sv @@
// Combinational opcode table: register read and write masks for one instruction.
module rad_decode (
  input  rad_pkg::instr_data_t  data,
  input  rad_pkg::instr_flags_t flags,
  output rad_pkg::access_t      access
);
  import rad_pkg::*;

  logic [7:0] op1;
  logic [7:0] op2;
  logic       tb;
  logic [1:0] md;
  logic [2:0] rg;
  logic [2:0] rm;
  logic [2:0] sib_idx;
  logic [2:0] sib_base;
  logic       eq;
  logic       immz;
  logic       immm1;
  logic       rep;
  logic       grp;
  logic       nop;
  logic       drd;
  logic       dwr;
  logic [7:0] rd;
  logic [7:0] wr;

  assign op1      = data.primary_opcode;
  assign op2      = data.second_opcode;
  assign tb       = flags.two_byte_form;
  assign md       = data.modrm_byte[7:6];
  assign rg       = data.modrm_byte[5:3];
  assign rm       = data.modrm_byte[2:0];
  assign sib_idx  = data.sib_byte[5:3];
  assign sib_base = data.sib_byte[2:0];
  assign eq       = (md == MOD_REG) && (rg == rm);
  assign immz     = (data.immediate == 32'h0000_0000);
  assign immm1    = (data.immediate == 32'hFFFF_FFFF);
  assign rep      = flags.prefix_f2 | flags.prefix_f3;
  assign grp      = (op1 >= 8'h80) && (op1 <= 8'h83);
  assign nop      = (immz && ((grp && (rg < 3'd2 || rg == 3'd5 || rg == 3'd6))
                              || op1 == 8'hC0 || op1 == 8'hC1))
                    || (immm1 && grp && rg == 3'd4);

  always_comb begin
    rd  = 8'h00;
    wr  = 8'h00;
    drd = 1'b0;
    dwr = 1'b0;

    // stack pointer effects
    if (flags.call_flag || op1 == 8'hC2 || op1 == 8'hC3 || op1 == 8'hCA || op1 == 8'hCB
        || op1 == 8'hCF || op1 == 8'h68 || op1 == 8'h6A || op1 == 8'h9C || op1 == 8'h9D
        || op1 == 8'hF1 || op1 == 8'h06 || op1 == 8'h07 || op1 == 8'h0E
        || op1 == 8'h16 || op1 == 8'h17 || op1 == 8'h1E || op1 == 8'h1F
        || (tb && (op2 == 8'hA0 || op2 == 8'hA1 || op2 == 8'hA8 || op2 == 8'hA9
                   || op2 == 8'h34 || op2 == 8'h35))) begin
      rd = rd | reg_bit(REG_ESP);
      wr = wr | reg_bit(REG_ESP);
    end

    // address registers
    if (flags.modrm_present) begin
      if (md != MOD_REG && rm == REG_ESP) begin
        if (sib_idx != REG_ESP) rd = rd | reg_bit(sib_idx);
        if (!(md == MOD_NO_DISP && sib_base == REG_EBP)) rd = rd | reg_bit(sib_base);
      end else if (md != MOD_REG && !(md == MOD_NO_DISP && rm == REG_EBP)) begin
        rd = rd | reg_bit(rm);
      end
    end

    // opcode rules, first match wins
    if (op1 == 8'h00 || op1 == 8'h01
        || ((op1 == 8'h08 || op1 == 8'h09 || op1 == 8'h20 || op1 == 8'h21) && !eq)
        || op1 == 8'h10 || op1 == 8'h11 || op1 == 8'h18 || op1 == 8'h19
        || op1 == 8'h28 || op1 == 8'h29 || op1 == 8'h30 || op1 == 8'h31) begin
      if (!((op1 == 8'h30 || op1 == 8'h31) && eq)) begin
        rd  = rd | reg_bit(rg);
        drd = 1'b1;
      end
      dwr = 1'b1;
    end else if (op1 == 8'h02 || op1 == 8'h03
        || ((op1 == 8'h0A || op1 == 8'h0B || op1 == 8'h22 || op1 == 8'h23) && !eq)
        || op1 == 8'h12 || op1 == 8'h13 || op1 == 8'h1A || op1 == 8'h1B
        || op1 == 8'h2A || op1 == 8'h2B || op1 == 8'h32 || op1 == 8'h33
        || (tb && op2 == 8'hAF)) begin
      if (!((op1 == 8'h32 || op1 == 8'h33) && eq)) begin
        rd  = rd | reg_bit(rg);
        drd = 1'b1;
      end
      wr = wr | reg_bit(rg);
    end else if ((!immz && (op1 == 8'h04 || op1 == 8'h05 || op1 == 8'h0C || op1 == 8'h0D
                            || op1 == 8'h2C || op1 == 8'h2D || op1 == 8'h34
                            || op1 == 8'h35))
        || op1 == 8'h14 || op1 == 8'h15 || op1 == 8'h1C || op1 == 8'h1D
        || (!immm1 && (op1 == 8'h24 || op1 == 8'h25))
        || op1 == 8'h3F || op1 == 8'h98 || op1 == 8'hD4 || op1 == 8'hD5) begin
      rd = rd | reg_bit(REG_EAX);
      wr = wr | reg_bit(REG_EAX);
    end else if (op1 == 8'h38 || op1 == 8'h39 || op1 == 8'h3A || op1 == 8'h3B
        || op1 == 8'h84 || op1 == 8'h85) begin
      rd  = rd | reg_bit(rg);
      drd = 1'b1;
    end else if (op1 == 8'h3C || op1 == 8'h3D) begin
      rd = rd | reg_bit(REG_EAX);
    end else if (op1[7:4] == 4'h4) begin
      rd = rd | reg_bit(op1[2:0]);
      wr = wr | reg_bit(op1[2:0]);
    end else if (op1[7:3] == 5'b01010) begin
      rd = rd | reg_bit(op1[2:0]) | reg_bit(REG_ESP);
      wr = wr | reg_bit(REG_ESP);
    end else if (op1[7:3] == 5'b01011) begin
      wr = wr | reg_bit(op1[2:0]) | reg_bit(REG_ESP);
      rd = rd | reg_bit(REG_ESP);
    end else if (op1 == 8'h60 || (op1 >= 8'hCC && op1 <= 8'hCE)) begin
      rd = 8'hFF;
      wr = wr | reg_bit(REG_ESP);
    end else if (op1 == 8'h61) begin
      wr = 8'hFF;
      rd = rd | reg_bit(REG_ESP);
    end else if (op1 == 8'h63) begin
      rd  = rd | reg_bit(rg);
      drd = 1'b1;
    end else if (op1 == 8'h69 || op1 == 8'h6B) begin
      wr  = wr | reg_bit(rg);
      drd = 1'b1;
    end else if (op1 == 8'h6C || op1 == 8'h6D) begin
      rd = rd | reg_bit(REG_EDX) | reg_bit(REG_EDI);
      wr = wr | reg_bit(REG_EDI);
    end else if (op1 == 8'h6E || op1 == 8'h6F) begin
      rd = rd | reg_bit(REG_EDX) | reg_bit(REG_ESI);
      wr = wr | reg_bit(REG_ESI);
    end else if (grp || op1 == 8'hC0 || op1 == 8'hC1 || op1 == 8'hD0 || op1 == 8'hD1
        || ((op1 == 8'hF6 || op1 == 8'hF7) && (rg == 3'd2 || rg == 3'd3))
        || op1 == 8'hFE || (op1 == 8'hFF && rg <= 3'd1)
        || (tb && op2 == 8'hBA && rg >= 3'd5)) begin
      drd = !nop;
      dwr = !nop;
    end else if (op1 == 8'hD2 || op1 == 8'hD3) begin
      rd  = rd | reg_bit(REG_ECX);
      drd = 1'b1;
      dwr = 1'b1;
    end else if (((op1 == 8'h86 || op1 == 8'h87) && !eq)
        || (tb && (op2 == 8'hC0 || op2 == 8'hC1))) begin
      rd  = rd | reg_bit(rg);
      wr  = wr | reg_bit(rg);
      drd = 1'b1;
      dwr = 1'b1;
    end else if ((op1 == 8'h88 || op1 == 8'h89) && !eq) begin
      rd  = rd | reg_bit(rg);
      dwr = 1'b1;
    end else if ((op1 == 8'h8A || op1 == 8'h8B) && !eq) begin
      wr  = wr | reg_bit(rg);
      drd = 1'b1;
    end else if (op1 == 8'h8C || op1 == 8'hC6 || op1 == 8'hC7
        || (tb && op2 == 8'h00 && rg <= 3'd1)) begin
      dwr = 1'b1;
    end else if (op1 == 8'h8D || op1 == 8'hC4 || op1 == 8'hC5
        || (tb && (op2 == 8'hB2 || op2 == 8'hB4 || op2 == 8'hB5))) begin
      wr = wr | reg_bit(rg);
    end else if (op1 == 8'h8E
        || ((op1 == 8'hF6 || op1 == 8'hF7) && rg <= 3'd1)
        || (tb && op2 == 8'h00 && rg >= 3'd2 && rg <= 3'd5)
        || (tb && op2 == 8'hBA && rg == 3'd4)
        || (op1 == 8'hFF && (rg == 3'd2 || rg == 3'd4))) begin
      drd = 1'b1;
    end else if (op1 == 8'h8F) begin
      rd  = rd | reg_bit(REG_ESP);
      wr  = wr | reg_bit(REG_ESP);
      dwr = 1'b1;
    end else if (op1 == 8'hFF && rg == 3'd6) begin
      rd  = rd | reg_bit(REG_ESP);
      wr  = wr | reg_bit(REG_ESP);
      drd = 1'b1;
    end else if (op1 >= 8'h91 && op1 <= 8'h97) begin
      rd = rd | reg_bit(REG_EAX) | reg_bit(op1[2:0]);
      wr = wr | reg_bit(REG_EAX) | reg_bit(op1[2:0]);
    end else if (op1 == 8'h99) begin
      rd = rd | reg_bit(REG_EAX);
      wr = wr | reg_bit(REG_EDX);
    end else if (op1 == 8'h9E || op1 == 8'hA2 || op1 == 8'hA3 || op1 == 8'hA8
        || op1 == 8'hA9 || op1 == 8'hE6 || op1 == 8'hE7) begin
      rd = rd | reg_bit(REG_EAX);
    end else if (op1 == 8'h9F || op1 == 8'hA0 || op1 == 8'hA1 || op1 == 8'hD6
        || op1 == 8'hE4 || op1 == 8'hE5) begin
      wr = wr | reg_bit(REG_EAX);
    end else if (op1 >= 8'hA4 && op1 <= 8'hA7) begin
      rd = rd | reg_bit(REG_ESI) | reg_bit(REG_EDI);
      wr = wr | reg_bit(REG_ESI) | reg_bit(REG_EDI);
    end else if (op1 == 8'hAA || op1 == 8'hAB || op1 == 8'hAE || op1 == 8'hAF) begin
      rd = rd | reg_bit(REG_EAX) | reg_bit(REG_EDI);
      wr = wr | reg_bit(REG_EDI);
    end else if (op1 == 8'hAC || op1 == 8'hAD) begin
      rd = rd | reg_bit(REG_ESI);
      wr = wr | reg_bit(REG_EAX) | reg_bit(REG_ESI);
    end else if (op1[7:4] == 4'hB) begin
      wr = wr | reg_bit(op1[2:0]);
    end else if (op1 == 8'hC8 || op1 == 8'hC9) begin
      rd = rd | reg_bit(REG_EBP) | reg_bit(REG_ESP);
      wr = wr | reg_bit(REG_EBP) | reg_bit(REG_ESP);
    end else if (op1 == 8'hD7) begin
      rd = rd | reg_bit(REG_EBX) | reg_bit(REG_EAX);
      wr = wr | reg_bit(REG_EAX);
    end else if (op1 >= 8'hE0 && op1 <= 8'hE3) begin
      rd = rd | reg_bit(REG_ECX);
    end else if (op1 == 8'hEC || op1 == 8'hED) begin
      rd = rd | reg_bit(REG_EDX);
      wr = wr | reg_bit(REG_EAX);
    end else if (op1 == 8'hEE || op1 == 8'hEF) begin
      rd = rd | reg_bit(REG_EDX) | reg_bit(REG_EAX);
    end else if (rep) begin
      // string count register, only when nothing above matched
      rd = rd | reg_bit(REG_ECX);
      wr = wr | reg_bit(REG_ECX);
    end else if (op1 == 8'hF6 && rg >= 3'd4) begin
      rd  = rd | reg_bit(REG_EAX);
      wr  = wr | reg_bit(REG_EAX);
      drd = 1'b1;
    end else if (op1 == 8'hF7 && rg >= 3'd4) begin
      rd  = rd | reg_bit(REG_EAX) | reg_bit(REG_EDX);
      wr  = wr | reg_bit(REG_EAX) | reg_bit(REG_EDX);
      drd = 1'b1;
    end else if (tb && op2 == 8'h01) begin
      if (rg == 3'd2) begin
        if (data.modrm_byte == 8'hD0) begin
          rd = rd | reg_bit(REG_ECX);
          wr = wr | reg_bit(REG_EAX) | reg_bit(REG_EDX);
        end else if (data.modrm_byte == 8'hD1) begin
          rd = rd | reg_bit(REG_ECX) | reg_bit(REG_EAX) | reg_bit(REG_EDX);
        end
      end else if (rg == 3'd4) begin
        dwr = 1'b1;
      end else if (rg == 3'd6) begin
        drd = 1'b1;
      end else if (data.modrm_byte == 8'hF9) begin
        rd = rd | reg_bit(REG_ECX);
        wr = wr | reg_bit(REG_EAX) | reg_bit(REG_EDX);
      end
    end else if (tb && (op2 == 8'h02 || op2 == 8'h03)) begin
      wr  = wr | reg_bit(rg);
      drd = 1'b1;
    end else if (tb && (op2 == 8'h20 || op2 == 8'h21)) begin
      wr = wr | reg_bit(rg);
    end else if (tb && (op2 == 8'h22 || op2 == 8'h23)) begin
      rd = rd | reg_bit(rg);
    end else if (tb && op2 == 8'h30) begin
      rd = rd | reg_bit(REG_EAX) | reg_bit(REG_EDX) | reg_bit(REG_ECX);
    end else if (tb && (op2 == 8'h31 || op2 == 8'h33)) begin
      wr = wr | reg_bit(REG_EAX) | reg_bit(REG_EDX);
    end else if (tb && op2 == 8'h32) begin
      rd = rd | reg_bit(REG_ECX);
      wr = wr | reg_bit(REG_EAX) | reg_bit(REG_EDX);
    end else if (tb && op2[7:4] == 4'h4) begin
      wr  = wr | reg_bit(rg);
      drd = 1'b1;
    end else if (tb && op2[7:4] == 4'h9) begin
      dwr = 1'b1;
    end else if (tb && op2 == 8'hA2) begin
      rd = rd | reg_bit(REG_EAX);
      wr = 8'hFF;
    end else if (tb && op2 == 8'hA3) begin
      rd  = rd | reg_bit(rg);
      drd = 1'b1;
    end else if (tb && (op2 == 8'hA4 || op2 == 8'hA5 || op2 == 8'hAC || op2 == 8'hAD)) begin
      if (op2 == 8'hA5 || op2 == 8'hAD) rd = rd | reg_bit(REG_ECX);
      rd  = rd | reg_bit(rg);
      drd = 1'b1;
      dwr = 1'b1;
    end else if (tb && (op2 == 8'hAB || op2 == 8'hB3 || op2 == 8'hBB)) begin
      rd  = rd | reg_bit(rg);
      drd = 1'b1;
      dwr = 1'b1;
    end else if (tb && (op2 == 8'hB0 || op2 == 8'hB1)) begin
      rd  = rd | reg_bit(rg) | reg_bit(REG_EAX);
      wr  = wr | reg_bit(REG_EAX);
      drd = 1'b1;
      dwr = 1'b1;
    end else if (tb && (op2 == 8'hB6 || op2 == 8'hB7 || op2 == 8'hBC || op2 == 8'hBD
                        || op2 == 8'hBE || op2 == 8'hBF || op2 == 8'hB8)) begin
      wr  = wr | reg_bit(rg);
      drd = 1'b1;
    end else if (tb && op2 == 8'hC7 && rg == 3'd1) begin
      rd = rd | reg_bit(REG_EAX) | reg_bit(REG_EDX);
      wr = wr | reg_bit(REG_EAX) | reg_bit(REG_EDX);
    end else if (tb && op2[7:3] == 5'h19) begin
      // bswap
      rd = rd | reg_bit(op2[2:0]);
      wr = wr | reg_bit(op2[2:0]);
    end

    // register-direct r/m operand
    if (flags.modrm_present && md == MOD_REG) begin
      if (drd) rd = rd | reg_bit(rm);
      if (dwr) wr = wr | reg_bit(rm);
    end
  end

  assign access.reads_mask  = rd;
  assign access.writes_mask = wr;

endmodule

@@ tb/sv/testbench.sv @@
// Self-checking testbench for x86_register_access_decoder_top: random and directed decode requests.
module testbench;
  import rad_pkg::*;

  // Holds the expected register masks of accepted requests and checks results in order
  class access_mask_board;
    access_t expected_masks[$];
    int      fail_count;

    function new();
      fail_count = 0;
    endfunction

    static function logic [7:0] reg_mask(input logic [2:0] n);
      return 8'b1 << n;
    endfunction

    // Read and write masks of one pre-split instruction
    function access_t decode_access(input instr_data_t d, input instr_flags_t f);
      logic [7:0] op1, op2, modrm, rd, wr;
      logic [1:0] md;
      logic [2:0] rg, rm, idx, base;
      bit         tb, hasm, rep, eq, immz, immm1, drd, dwr, grp, nop;
      access_t    res;
      op1   = d.primary_opcode;
      op2   = d.second_opcode;
      modrm = d.modrm_byte;
      md    = modrm[7:6];
      rg    = modrm[5:3];
      rm    = modrm[2:0];
      idx   = d.sib_byte[5:3];
      base  = d.sib_byte[2:0];
      tb    = f.two_byte_form;
      hasm  = f.modrm_present;
      rep   = f.prefix_f2 | f.prefix_f3;
      eq    = (md == MOD_REG) && (rg == rm);
      immz  = (d.immediate == 32'h0000_0000);
      immm1 = (d.immediate == 32'hFFFF_FFFF);
      rd    = 8'h00;
      wr    = 8'h00;
      drd   = 1'b0;
      dwr   = 1'b0;

      // stack pointer side effects
      if (f.call_flag || op1 inside {8'hC2, 8'hC3, 8'hCA, 8'hCB, 8'hCF, 8'h68, 8'h6A, 8'h9C,
                                     8'h9D, 8'hF1, 8'h06, 8'h07, 8'h0E, 8'h16, 8'h17,
                                     8'h1E, 8'h1F}
          || (tb && op2 inside {8'hA0, 8'hA1, 8'hA8, 8'hA9, 8'h34, 8'h35})) begin
        rd |= reg_mask(REG_ESP);
        wr |= reg_mask(REG_ESP);
      end

      // address registers from ModR/M and SIB
      if (hasm) begin
        if (md != MOD_REG && rm == REG_ESP) begin
          if (idx != REG_ESP) rd |= reg_mask(idx);
          if (!(md == MOD_NO_DISP && base == REG_EBP)) rd |= reg_mask(base);
        end else if (md != MOD_REG && !(md == MOD_NO_DISP && rm == REG_EBP)) begin
          rd |= reg_mask(rm);
        end
      end

      // first matching opcode rule wins
      if (op1 inside {8'h00, 8'h01, 8'h10, 8'h11, 8'h18, 8'h19, 8'h28, 8'h29, 8'h30, 8'h31}
          || (op1 inside {8'h08, 8'h09, 8'h20, 8'h21} && !eq)) begin
        if (!(op1 inside {8'h30, 8'h31} && eq)) begin
          rd |= reg_mask(rg);
          drd = 1'b1;
        end
        dwr = 1'b1;
      end else if (op1 inside {8'h02, 8'h03, 8'h12, 8'h13, 8'h1A, 8'h1B, 8'h2A, 8'h2B,
                               8'h32, 8'h33}
          || (op1 inside {8'h0A, 8'h0B, 8'h22, 8'h23} && !eq) || (tb && op2 == 8'hAF)) begin
        if (!(op1 inside {8'h32, 8'h33} && eq)) begin
          rd |= reg_mask(rg);
          drd = 1'b1;
        end
        wr |= reg_mask(rg);
      end else if ((!immz && op1 inside {8'h04, 8'h05, 8'h0C, 8'h0D, 8'h2C, 8'h2D, 8'h34,
                                         8'h35})
          || op1 inside {8'h14, 8'h15, 8'h1C, 8'h1D, 8'h3F, 8'h98, 8'hD4, 8'hD5}
          || (!immm1 && op1 inside {8'h24, 8'h25})) begin
        rd |= reg_mask(REG_EAX);
        wr |= reg_mask(REG_EAX);
      end else if (op1 inside {8'h38, 8'h39, 8'h3A, 8'h3B, 8'h84, 8'h85}) begin
        rd |= reg_mask(rg);
        drd = 1'b1;
      end else if (op1 inside {8'h3C, 8'h3D}) begin
        rd |= reg_mask(REG_EAX);
      end else if (op1 inside {[8'h40:8'h4F]}) begin
        rd |= reg_mask(op1[2:0]);
        wr |= reg_mask(op1[2:0]);
      end else if (op1 inside {[8'h50:8'h57]}) begin
        rd |= reg_mask(op1[2:0]) | reg_mask(REG_ESP);
        wr |= reg_mask(REG_ESP);
      end else if (op1 inside {[8'h58:8'h5F]}) begin
        wr |= reg_mask(op1[2:0]) | reg_mask(REG_ESP);
        rd |= reg_mask(REG_ESP);
      end else if (op1 == 8'h60 || op1 inside {[8'hCC:8'hCE]}) begin
        rd = 8'hFF;
        wr |= reg_mask(REG_ESP);
      end else if (op1 == 8'h61) begin
        wr = 8'hFF;
        rd |= reg_mask(REG_ESP);
      end else if (op1 == 8'h63) begin
        rd |= reg_mask(rg);
        drd = 1'b1;
      end else if (op1 inside {8'h69, 8'h6B}) begin
        wr |= reg_mask(rg);
        drd = 1'b1;
      end else if (op1 inside {8'h6C, 8'h6D}) begin
        rd |= reg_mask(REG_EDX) | reg_mask(REG_EDI);
        wr |= reg_mask(REG_EDI);
      end else if (op1 inside {8'h6E, 8'h6F}) begin
        rd |= reg_mask(REG_EDX) | reg_mask(REG_ESI);
        wr |= reg_mask(REG_ESI);
      end else if (op1 inside {[8'h80:8'h83], 8'hC0, 8'hC1, 8'hD0, 8'hD1, 8'hFE}
          || (op1 inside {8'hF6, 8'hF7} && rg inside {3'd2, 3'd3})
          || (op1 == 8'hFF && rg <= 3'd1) || (tb && op2 == 8'hBA && rg >= 3'd5)) begin
        // immediate forms that leave the operand unchanged touch nothing
        grp = op1 inside {[8'h80:8'h83]};
        nop = (immz && ((grp && (rg < 3'd2 || rg == 3'd5 || rg == 3'd6))
                        || op1 inside {8'hC0, 8'hC1}))
              || (immm1 && grp && rg == 3'd4);
        drd = !nop;
        dwr = !nop;
      end else if (op1 inside {8'hD2, 8'hD3}) begin
        rd |= reg_mask(REG_ECX);
        drd = 1'b1;
        dwr = 1'b1;
      end else if ((op1 inside {8'h86, 8'h87} && !eq) || (tb && op2 inside {8'hC0, 8'hC1})) begin
        rd |= reg_mask(rg);
        wr |= reg_mask(rg);
        drd = 1'b1;
        dwr = 1'b1;
      end else if (op1 inside {8'h88, 8'h89} && !eq) begin
        rd |= reg_mask(rg);
        dwr = 1'b1;
      end else if (op1 inside {8'h8A, 8'h8B} && !eq) begin
        wr |= reg_mask(rg);
        drd = 1'b1;
      end else if (op1 inside {8'h8C, 8'hC6, 8'hC7} || (tb && op2 == 8'h00 && rg <= 3'd1)) begin
        dwr = 1'b1;
      end else if (op1 inside {8'h8D, 8'hC4, 8'hC5}
          || (tb && op2 inside {8'hB2, 8'hB4, 8'hB5})) begin
        wr |= reg_mask(rg);
      end else if (op1 == 8'h8E || (op1 inside {8'hF6, 8'hF7} && rg <= 3'd1)
          || (tb && op2 == 8'h00 && rg inside {[3'd2:3'd5]})
          || (tb && op2 == 8'hBA && rg == 3'd4)
          || (op1 == 8'hFF && rg inside {3'd2, 3'd4})) begin
        drd = 1'b1;
      end else if (op1 == 8'h8F) begin
        rd |= reg_mask(REG_ESP);
        wr |= reg_mask(REG_ESP);
        dwr = 1'b1;
      end else if (op1 == 8'hFF && rg == 3'd6) begin
        rd |= reg_mask(REG_ESP);
        wr |= reg_mask(REG_ESP);
        drd = 1'b1;
      end else if (op1 inside {[8'h91:8'h97]}) begin
        rd |= reg_mask(REG_EAX) | reg_mask(op1[2:0]);
        wr |= reg_mask(REG_EAX) | reg_mask(op1[2:0]);
      end else if (op1 == 8'h99) begin
        rd |= reg_mask(REG_EAX);
        wr |= reg_mask(REG_EDX);
      end else if (op1 inside {8'h9E, 8'hA2, 8'hA3, 8'hA8, 8'hA9, 8'hE6, 8'hE7}) begin
        rd |= reg_mask(REG_EAX);
      end else if (op1 inside {8'h9F, 8'hA0, 8'hA1, 8'hD6, 8'hE4, 8'hE5}) begin
        wr |= reg_mask(REG_EAX);
      end else if (op1 inside {[8'hA4:8'hA7]}) begin
        rd |= reg_mask(REG_ESI) | reg_mask(REG_EDI);
        wr |= reg_mask(REG_ESI) | reg_mask(REG_EDI);
      end else if (op1 inside {8'hAA, 8'hAB, 8'hAE, 8'hAF}) begin
        rd |= reg_mask(REG_EAX) | reg_mask(REG_EDI);
        wr |= reg_mask(REG_EDI);
      end else if (op1 inside {8'hAC, 8'hAD}) begin
        rd |= reg_mask(REG_ESI);
        wr |= reg_mask(REG_EAX) | reg_mask(REG_ESI);
      end else if (op1 inside {[8'hB0:8'hBF]}) begin
        wr |= reg_mask(op1[2:0]);
      end else if (op1 inside {8'hC8, 8'hC9}) begin
        rd |= reg_mask(REG_EBP) | reg_mask(REG_ESP);
        wr |= reg_mask(REG_EBP) | reg_mask(REG_ESP);
      end else if (op1 == 8'hD7) begin
        rd |= reg_mask(REG_EBX) | reg_mask(REG_EAX);
        wr |= reg_mask(REG_EAX);
      end else if (op1 inside {[8'hE0:8'hE3]}) begin
        rd |= reg_mask(REG_ECX);
      end else if (op1 inside {8'hEC, 8'hED}) begin
        rd |= reg_mask(REG_EDX);
        wr |= reg_mask(REG_EAX);
      end else if (op1 inside {8'hEE, 8'hEF}) begin
        rd |= reg_mask(REG_EDX) | reg_mask(REG_EAX);
      end else if (rep) begin
        rd |= reg_mask(REG_ECX);
        wr |= reg_mask(REG_ECX);
      end else if (op1 == 8'hF6 && rg >= 3'd4) begin
        rd |= reg_mask(REG_EAX);
        wr |= reg_mask(REG_EAX);
        drd = 1'b1;
      end else if (op1 == 8'hF7 && rg >= 3'd4) begin
        rd |= reg_mask(REG_EAX) | reg_mask(REG_EDX);
        wr |= reg_mask(REG_EAX) | reg_mask(REG_EDX);
        drd = 1'b1;
      end else if (tb && op2 == 8'h01) begin
        if (rg == 3'd2) begin
          if (modrm == 8'hD0) begin
            rd |= reg_mask(REG_ECX);
            wr |= reg_mask(REG_EAX) | reg_mask(REG_EDX);
          end else if (modrm == 8'hD1) begin
            rd |= reg_mask(REG_ECX) | reg_mask(REG_EAX) | reg_mask(REG_EDX);
          end
        end else if (rg == 3'd4) begin
          dwr = 1'b1;
        end else if (rg == 3'd6) begin
          drd = 1'b1;
        end else if (modrm == 8'hF9) begin
          rd |= reg_mask(REG_ECX);
          wr |= reg_mask(REG_EAX) | reg_mask(REG_EDX);
        end
      end else if (tb && op2 inside {8'h02, 8'h03}) begin
        wr |= reg_mask(rg);
        drd = 1'b1;
      end else if (tb && op2 inside {8'h20, 8'h21}) begin
        wr |= reg_mask(rg);
      end else if (tb && op2 inside {8'h22, 8'h23}) begin
        rd |= reg_mask(rg);
      end else if (tb && op2 == 8'h30) begin
        rd |= reg_mask(REG_EAX) | reg_mask(REG_EDX) | reg_mask(REG_ECX);
      end else if (tb && op2 inside {8'h31, 8'h33}) begin
        wr |= reg_mask(REG_EAX) | reg_mask(REG_EDX);
      end else if (tb && op2 == 8'h32) begin
        rd |= reg_mask(REG_ECX);
        wr |= reg_mask(REG_EAX) | reg_mask(REG_EDX);
      end else if (tb && op2 inside {[8'h40:8'h4F]}) begin
        wr |= reg_mask(rg);
        drd = 1'b1;
      end else if (tb && op2 inside {[8'h90:8'h9F]}) begin
        dwr = 1'b1;
      end else if (tb && op2 == 8'hA2) begin
        rd |= reg_mask(REG_EAX);
        wr = 8'hFF;
      end else if (tb && op2 == 8'hA3) begin
        rd |= reg_mask(rg);
        drd = 1'b1;
      end else if (tb && op2 inside {8'hA4, 8'hA5, 8'hAC, 8'hAD}) begin
        if (op2 inside {8'hA5, 8'hAD}) rd |= reg_mask(REG_ECX);
        rd |= reg_mask(rg);
        drd = 1'b1;
        dwr = 1'b1;
      end else if (tb && op2 inside {8'hAB, 8'hB3, 8'hBB}) begin
        rd |= reg_mask(rg);
        drd = 1'b1;
        dwr = 1'b1;
      end else if (tb && op2 inside {8'hB0, 8'hB1}) begin
        rd |= reg_mask(rg) | reg_mask(REG_EAX);
        wr |= reg_mask(REG_EAX);
        drd = 1'b1;
        dwr = 1'b1;
      end else if (tb && op2 inside {8'hB6, 8'hB7, 8'hB8, 8'hBC, 8'hBD, 8'hBE, 8'hBF}) begin
        wr |= reg_mask(rg);
        drd = 1'b1;
      end else if (tb && op2 == 8'hC7 && rg == 3'd1) begin
        rd |= reg_mask(REG_EAX) | reg_mask(REG_EDX);
        wr |= reg_mask(REG_EAX) | reg_mask(REG_EDX);
      end else if (tb && op2[7:3] == 5'h19) begin
        rd |= reg_mask(op2[2:0]);
        wr |= reg_mask(op2[2:0]);
      end

      // register-direct r/m operand
      if (hasm && md == MOD_REG) begin
        if (drd) rd |= reg_mask(rm);
        if (dwr) wr |= reg_mask(rm);
      end
      res.reads_mask  = rd;
      res.writes_mask = wr;
      return res;
    endfunction

    function void note_request(input instr_data_t d, input instr_flags_t f);
      expected_masks.push_back(decode_access(d, f));
    endfunction

    task report_mismatch(input string what, input logic [7:0] got, input logic [7:0] want);
      $display("%0t: %s: got %02h, expected %02h", $time, what, got, want);
      fail_count++;
    endtask

    task check_result(input access_t got);
      access_t want;
      if (expected_masks.size() == 0) begin
        report_mismatch("result with no request pending, reads_mask", got.reads_mask, 8'hxx);
        return;
      end
      want = expected_masks.pop_front();
      if (got.reads_mask !== want.reads_mask)
        report_mismatch("reads_mask", got.reads_mask, want.reads_mask);
      if (got.writes_mask !== want.writes_mask)
        report_mismatch("writes_mask", got.writes_mask, want.writes_mask);
    endtask
  endclass

  localparam instr_flags_t F_NONE  = 5'b00000;
  localparam instr_flags_t F_TWO   = 5'b00001;
  localparam instr_flags_t F_MODRM = 5'b00010;
  localparam instr_flags_t F_CALL  = 5'b00100;
  localparam instr_flags_t F_REPNE = 5'b01000;
  localparam instr_flags_t F_REP   = 5'b10000;

  localparam int RANDOM_PER_PACE = 234;
  localparam int HOLD_AT_RESULT  = 520;
  localparam int HOLD_CYCLES     = 40;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  s_tvalid;
  logic                  s_tready;
  instr_data_t           s_tdata;
  instr_flags_t          s_tuser;
  logic                  m_tvalid;
  logic                  m_tready;
  logic [OUT_DATA_W-1:0] m_tdata;

  access_mask_board masks;
  int               src_idle_pct = 37;
  int               rx_idle_pct  = 62;
  int               result_total = 0;

  x86_register_access_decoder_top i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always #5 clk = ~clk;

  // Offer one request, idling first at the current rate; return once it is taken
  task automatic send_instr(input logic [7:0] op1, input logic [7:0] op2,
                            input logic [7:0] modrm, input logic [7:0] sib,
                            input logic [31:0] imm, input instr_flags_t flags);
    instr_data_t d;
    d.primary_opcode = op1;
    d.second_opcode  = op2;
    d.modrm_byte     = modrm;
    d.sib_byte       = sib;
    d.immediate      = imm;
    while ($urandom_range(0, 99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= d;
    s_tuser  <= flags;
    do @(posedge clk); while (!s_tready);
    masks.note_request(d, flags);
  endtask

  task automatic send_random_instr();
    logic [7:0]   op1, op2, modrm;
    logic [2:0]   r;
    logic [31:0]  imm;
    instr_flags_t flags;
    int           pick;
    flags.two_byte_form = ($urandom_range(0, 99) < 30);
    flags.modrm_present = ($urandom_range(0, 99) < 80);
    flags.call_flag     = ($urandom_range(0, 99) < 10);
    flags.prefix_f2     = ($urandom_range(0, 99) < 12);
    flags.prefix_f3     = ($urandom_range(0, 99) < 12);
    op1 = 8'($urandom_range(0, 255));
    if (flags.two_byte_form && $urandom_range(0, 99) < 85) op1 = 8'h0F;
    pick = $urandom_range(0, 3);
    if (pick == 0) op2 = 8'($urandom_range(8'hA0, 8'hCF));
    else if (pick == 1) op2 = 8'($urandom_range(8'h00, 8'h4F));
    else op2 = 8'($urandom_range(0, 255));
    modrm = 8'($urandom_range(0, 255));
    if ($urandom_range(0, 99) < 30) begin
      // same-register form
      r     = 3'($urandom_range(0, 7));
      modrm = {MOD_REG, r, r};
    end
    if (flags.two_byte_form && op2 == 8'h01 && $urandom_range(0, 1) == 1) begin
      pick = $urandom_range(0, 2);
      modrm = (pick == 0) ? 8'hD0 : (pick == 1) ? 8'hD1 : 8'hF9;
    end
    pick = $urandom_range(0, 99);
    if (pick < 20) imm = 32'h0000_0000;
    else if (pick < 40) imm = 32'hFFFF_FFFF;
    else if (pick < 55) imm = 32'($urandom_range(1, 255));
    else imm = $urandom;
    send_instr(op1, op2, modrm, 8'($urandom_range(0, 255)), imm, flags);
  endtask

  // Receiver: random backpressure, plus one long hold-off so the block fills up
  initial begin
    bit held_off;
    held_off = 1'b0;
    m_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!held_off && result_total >= HOLD_AT_RESULT) begin
        held_off = 1'b1;
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      masks.check_result(access_t'(m_tdata));
      result_total++;
    end
  end

  initial begin
    #2000000;
    $display("x86_register_access_decoder_top: mismatch");
    $finish;
  end

  initial begin
    masks = new();
    rst      <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata  <= '0;
    s_tuser  <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // extremes of every field
    send_instr(8'h00, 8'h00, 8'h00, 8'h00, 32'h0000_0000, F_MODRM);
    send_instr(8'hFF, 8'hFF, 8'hFF, 8'hFF, 32'hFFFF_FFFF,
               F_TWO | F_MODRM | F_CALL | F_REPNE | F_REP);
    // xor X,X does not read the reg operand
    send_instr(8'h31, 8'h00, 8'hDB, 8'h00, 32'h0000_0000, F_MODRM);
    send_instr(8'h33, 8'h00, 8'hC9, 8'h00, 32'h0000_0000, F_MODRM);
    // and/or/mov/xchg X,X match no rule; with rep the prefix rule applies
    send_instr(8'h21, 8'h00, 8'hF6, 8'h00, 32'h0000_0000, F_MODRM | F_REP);
    send_instr(8'h0B, 8'h00, 8'hD2, 8'h00, 32'h0000_0000, F_MODRM);
    send_instr(8'h89, 8'h00, 8'hED, 8'h00, 32'h0000_0000, F_MODRM);
    send_instr(8'h8B, 8'h00, 8'hE4, 8'h00, 32'h0000_0000, F_MODRM);
    send_instr(8'h87, 8'h00, 8'hFF, 8'h00, 32'h0000_0000, F_MODRM);
    // immediates that make the op a no-op
    send_instr(8'h05, 8'h00, 8'h00, 8'h00, 32'h0000_0000, F_NONE);
    send_instr(8'h25, 8'h00, 8'h00, 8'h00, 32'hFFFF_FFFF, F_NONE);
    send_instr(8'h83, 8'h00, 8'hC3, 8'h00, 32'h0000_0000, F_MODRM);
    send_instr(8'h81, 8'h00, 8'hE1, 8'h00, 32'hFFFF_FFFF, F_MODRM);
    send_instr(8'hC1, 8'h00, 8'hE2, 8'h00, 32'h0000_0000, F_MODRM);
    // SIB without index or base, SIB with base only, displacement alone
    send_instr(8'h8B, 8'h00, 8'h04, 8'h25, 32'h0000_0000, F_MODRM);
    send_instr(8'h03, 8'h00, 8'h44, 8'hE3, 32'h0000_0000, F_MODRM);
    send_instr(8'h8B, 8'h00, 8'h0D, 8'h00, 32'h0000_0000, F_MODRM);
    // rep ahead of mul/div, then div alone
    send_instr(8'hF6, 8'h00, 8'hE0, 8'h00, 32'h0000_0000, F_MODRM | F_REP);
    send_instr(8'hF7, 8'h00, 8'hF3, 8'h00, 32'h0000_0000, F_MODRM);
    // 0F 01 system forms
    send_instr(8'h0F, 8'h01, 8'hD0, 8'h00, 32'h0000_0000, F_TWO | F_MODRM);
    send_instr(8'h0F, 8'h01, 8'hD1, 8'h00, 32'h0000_0000, F_TWO | F_MODRM);
    send_instr(8'h0F, 8'h01, 8'hF9, 8'h00, 32'h0000_0000, F_TWO | F_MODRM);
    send_instr(8'h9F, 8'h00, 8'h00, 8'h00, 32'h0000_0000, F_NONE);
    send_instr(8'hE8, 8'h00, 8'h00, 8'h00, 32'h0000_1000, F_CALL);
    send_instr(8'h0F, 8'hC8, 8'h00, 8'h00, 32'h0000_0000, F_TWO);
    send_instr(8'h0F, 8'hAF, 8'hC1, 8'h00, 32'h0000_0000, F_TWO | F_MODRM);

    repeat (RANDOM_PER_PACE) send_random_instr();
    src_idle_pct = 62;
    rx_idle_pct  = 37;
    repeat (RANDOM_PER_PACE) send_random_instr();
    src_idle_pct = 0;
    rx_idle_pct  = 0;
    repeat (RANDOM_PER_PACE) send_random_instr();
    s_tvalid <= 1'b0;

    // drain, then give the two pipeline stages time to show any extra result
    while (masks.expected_masks.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (masks.fail_count == 0) begin
      $display("x86_register_access_decoder_top: match");
    end else begin
      $display("x86_register_access_decoder_top: mismatch");
    end
    $finish;
  end
endmodule

@@ sim.f @@
src/rad_pkg.sv
src/rad_decode.sv
src/x86_register_access_decoder_top.sv
tb/sv/testbench.sv
